>>> src/ica_pkg.sv
// ----------------------------------------------------------------------------
// ica_pkg
// shared types and codes for the interval capacity admission block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ica_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // input operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RESERVE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_GRANTED  = 2'd0;
  localparam logic [1:0] STAT_OVER     = 2'd1;
  localparam logic [1:0] STAT_SKIPPED  = 2'd2;
  localparam logic [1:0] STAT_BADRANGE = 2'd3;

  // field widths
  localparam int SLOT_W  = 10;
  localparam int AMT_W   = 32;
  localparam int CNT_W   = 20;
  localparam int CFG_W   = 11;
  // wide enough for any slot count up to 65536
  localparam int CMP_W   = 17;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

>>> src/ica_cap_ram.sv
// ----------------------------------------------------------------------------
// ica_cap_ram
// remaining capacity store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ica_cap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ica_pkg::AMT_W-1:0]   wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [ica_pkg::AMT_W-1:0]   rd_data
);

  logic [ica_pkg::AMT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/interval_capacity_admission_core.sv
// ----------------------------------------------------------------------------
// interval_capacity_admission_core
// load: no result. a reservation over n slots is paced by one capacity read
// per cycle through a single subtract/compare unit, once for the check pass
// and once for the update pass; bad range or skip goes straight to the result.
// one item in flight at a time.
// synchronous active-low reset clears counters, failure record and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_capacity_admission_core #(
  parameter int SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [ica_pkg::SLOT_W-1:0]    in_first_slot,
  input  wire logic [ica_pkg::SLOT_W-1:0]    in_last_slot,
  input  wire logic [ica_pkg::AMT_W-1:0]     in_amount,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    out_status,
  output logic      [ica_pkg::CNT_W-1:0]     out_request_number,
  output logic      [ica_pkg::CNT_W-1:0]     out_first_failure,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [ica_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = ica_pkg::CMP_W;
  localparam int SW = ica_pkg::SLOT_W;
  localparam int DW = ica_pkg::AMT_W;
  localparam int NW = ica_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  ica_pkg::state_t state_r, state_nxt;

  logic [ica_pkg::CFG_W-1:0] slots_in_use_r;

  // current item
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic [DW-1:0] amt_r, amt_nxt;

  // series bookkeeping
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] fail_r, fail_nxt;
  logic [1:0]    stat_r, stat_nxt;

  // slot walker: issue side, and a compare side that follows in the next cycle
  logic [SW-1:0] cur_r, cur_nxt;
  logic          issuing_r, issuing_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic [SW-1:0] pa_r, pa_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [NW-1:0] out_req_r;
  logic [NW-1:0] out_ff_r;
  logic          out_load;

  // --------------------------------------------------------------------------
  // handshakes and range checks
  // --------------------------------------------------------------------------
  logic in_fire, out_fire;
  logic [CW-1:0] live_slots;
  logic load_hit, bad_range;
  logic cur_at_hi;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // effective slot count is the smaller of the register and the store depth
  assign live_slots = (CW'(slots_in_use_r) < CW'(SLOTS)) ? CW'(slots_in_use_r)
                                                         : CW'(SLOTS);
  assign load_hit   = CW'(in_first_slot) < CW'(SLOTS);
  assign bad_range  = (in_first_slot > in_last_slot) ||
                      (CW'(in_last_slot) >= live_slots);
  assign cur_at_hi  = (cur_r == hi_r);

  // --------------------------------------------------------------------------
  // shared subtract/compare unit: borrow means capacity below the request
  // --------------------------------------------------------------------------
  logic [DW-1:0] rd_data;
  logic [DW:0]   diff;
  logic          short_cap;

  assign diff      = {1'b0, rd_data} - {1'b0, amt_r};
  assign short_cap = diff[DW];

  // --------------------------------------------------------------------------
  // capacity store
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [DW-1:0] ram_wd;
  logic          ram_re;
  logic [AW-1:0] ram_ra;

  ica_cap_ram #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ica_pkg::ST_IDLE: begin
        if (in_fire && (in_op == ica_pkg::OP_RESERVE)) begin
          // bad range and skip go straight to the result
          if (bad_range || (fail_r != '0)) begin
            state_nxt = ica_pkg::ST_FINISH;
          end else begin
            state_nxt = ica_pkg::ST_CHECK;
          end
        end
      end
      ica_pkg::ST_CHECK: begin
        if (pend_r) begin
          if (short_cap) begin
            state_nxt = ica_pkg::ST_FINISH;
          end else if (pend_last_r) begin
            state_nxt = ica_pkg::ST_UPDATE;
          end
        end
      end
      ica_pkg::ST_UPDATE: begin
        if (pend_r && pend_last_r) begin
          state_nxt = ica_pkg::ST_FINISH;
        end
      end
      ica_pkg::ST_FINISH: begin
        // wait until the result register is free
        if (!out_valid_r || out_ready) begin
          state_nxt = ica_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ica_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs of the sequencer: handshake and memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_wa   = AW'(pa_r);
    ram_wd   = diff[DW-1:0];
    ram_re   = 1'b0;
    ram_ra   = AW'(cur_r);
    out_load = 1'b0;
    unique case (state_r)
      ica_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // load writes straight from the input ports
        if (in_fire && (in_op == ica_pkg::OP_LOAD) && load_hit) begin
          ram_we = 1'b1;
          ram_wa = AW'(in_first_slot);
          ram_wd = in_amount;
        end
      end
      ica_pkg::ST_CHECK: begin
        ram_re = issuing_r;
      end
      ica_pkg::ST_UPDATE: begin
        ram_re = issuing_r;
        // write back the slot read in the previous cycle
        ram_we = pend_r;
      end
      ica_pkg::ST_FINISH: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    amt_nxt       = amt_r;
    count_nxt     = count_r;
    fail_nxt      = fail_r;
    stat_nxt      = stat_r;
    cur_nxt       = cur_r;
    issuing_nxt   = issuing_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    pa_nxt        = pa_r;
    out_valid_nxt = out_valid_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    // walker advances in both passes
    if ((state_r == ica_pkg::ST_CHECK) || (state_r == ica_pkg::ST_UPDATE)) begin
      pend_nxt      = issuing_r;
      pend_last_nxt = issuing_r && cur_at_hi;
      pa_nxt        = cur_r;
      if (issuing_r) begin
        if (cur_at_hi) begin
          issuing_nxt = 1'b0;
        end else begin
          cur_nxt = cur_r + SW'(1);
        end
      end
    end

    unique case (state_r)
      ica_pkg::ST_IDLE: begin
        if (in_fire) begin
          lo_nxt      = in_first_slot;
          hi_nxt      = in_last_slot;
          amt_nxt     = in_amount;
          cur_nxt     = in_first_slot;
          issuing_nxt = 1'b1;
          if (in_op == ica_pkg::OP_LOAD) begin
            // a load starts a new series
            count_nxt = '0;
            fail_nxt  = '0;
          end else begin
            if (count_r != ica_pkg::COUNT_MAX) begin
              count_nxt = count_r + NW'(1);
            end
            priority if (bad_range) begin
              stat_nxt = ica_pkg::STAT_BADRANGE;
            end else if (fail_r != '0) begin
              stat_nxt = ica_pkg::STAT_SKIPPED;
            end else begin
              stat_nxt = ica_pkg::STAT_GRANTED;
            end
          end
        end
      end
      ica_pkg::ST_CHECK: begin
        if (pend_r) begin
          if (short_cap) begin
            stat_nxt = ica_pkg::STAT_OVER;
            fail_nxt = count_r;
          end else if (pend_last_r) begin
            // restart the walker for the update pass
            cur_nxt       = lo_r;
            issuing_nxt   = 1'b1;
            pend_nxt      = 1'b0;
            pend_last_nxt = 1'b0;
          end
        end
      end
      ica_pkg::ST_UPDATE: begin
        stat_nxt = ica_pkg::STAT_GRANTED;
      end
      ica_pkg::ST_FINISH: begin
        stat_nxt = stat_r;
      end
      default: begin
        stat_nxt = stat_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ica_pkg::ST_IDLE;
      slots_in_use_r <= ica_pkg::CFG_W'(1024);
      count_r        <= '0;
      fail_r         <= '0;
      issuing_r      <= 1'b0;
      pend_r         <= 1'b0;
      pend_last_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fail_r      <= fail_nxt;
      issuing_r   <= issuing_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slots_in_use_r <= cfg_wr_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    amt_r  <= amt_nxt;
    stat_r <= stat_nxt;
    cur_r  <= cur_nxt;
    pa_r   <= pa_nxt;
    if (out_load) begin
      out_status_r <= stat_r;
      out_req_r    <= count_r;
      out_ff_r     <= fail_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_request_number = out_req_r;
  assign out_first_failure  = out_ff_r;

`ifndef NO_ASSERTIONS
  // a skipped reservation always sees a recorded failure
  a_skip_has_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ica_pkg::STAT_SKIPPED)) |-> (out_first_failure != '0))
    else $error("skipped result without a recorded failure");

  // an over-capacity result is the first failure itself
  a_over_is_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ica_pkg::STAT_OVER)) |->
      (out_first_failure == out_request_number))
    else $error("over-capacity result does not match failure record");

  // grants only happen while no failure is recorded
  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ica_pkg::STAT_GRANTED)) |-> (out_first_failure == '0))
    else $error("grant reported with a failure on record");

  // capacity is written only by a load transfer or the update pass
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ica_pkg::ST_UPDATE) || in_fire))
    else $error("capacity write outside load or update");

  // the failure record only changes on a load or when a check comes up short
  a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ((fail_r != '0) && !in_fire) |=> $stable(fail_r))
    else $error("failure record changed without a load");
`endif

endmodule

`default_nettype wire
